// File: hw/rtl/two_pool_next_fit_register_allocator_defines.svh
// Assertion macros for the two-pool register allocator.
`ifndef TWO_POOL_NEXT_FIT_REGISTER_ALLOCATOR_DEFINES_SVH
`define TWO_POOL_NEXT_FIT_REGISTER_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define TPNF_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("allocator assertion failed");

// Next-cycle implication, disabled during reset.
`define TPNF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("allocator assertion failed");

`endif

// File: hw/rtl/tpnf_pkg.sv
// Shared types and codes for the two-pool register allocator.
`timescale 1ns / 1ps
`default_nettype none
package tpnf_pkg;

   localparam int CHUNK = 16;
   localparam int CB    = 4;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   localparam logic POOL_INT   = 1'b0;
   localparam logic POOL_FLOAT = 1'b1;

   localparam logic [1:0] ST_ALLOC   = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_FREED   = 2'd2;
   localparam logic [1:0] ST_IGNORED = 2'd3;

   typedef struct packed {
      logic       mode;
      logic       pool;
      logic [5:0] reg_index;
   } tpnf_req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_index;
      logic       granted_pool;
   } tpnf_rsp_type;

   typedef struct packed {
      logic       mode;
      logic [5:0] reg_index;
   } tpnf_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [5:0] granted_index;
   } tpnf_result_type;

endpackage
`default_nettype wire

// File: hw/rtl/tpnf_req_if.sv
// Request channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface tpnf_req_if;
   logic                  valid;
   logic                  ready;
   tpnf_pkg::tpnf_req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tpnf_rsp_if.sv
// Response channel interface.
`timescale 1ns / 1ps
`default_nettype none
interface tpnf_rsp_if;
   logic                  valid;
   logic                  ready;
   tpnf_pkg::tpnf_rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/tpnf_pool.sv
// One register pool: busy bitmap memory, next pointer, busy count and search sequencer.
`timescale 1ns / 1ps
`default_nettype none
module tpnf_pool #(
   parameter int REGS = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   input  wire tpnf_pkg::tpnf_cmd_type cmd,
   input  wire                        ack,
   output logic                       done,
   output tpnf_pkg::tpnf_result_type  result
);
   import tpnf_pkg::*;

   localparam int ROWS = (REGS + CHUNK - 1) / CHUNK;
   localparam int RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PW   = RW + CB;
   localparam int UW   = $clog2(REGS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_FREE = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [RW-1:0]    row_ff, row_in;
   logic [CB-1:0]    bit_ff, bit_in;
   logic             first_ff, first_in;
   logic [PW-1:0]    next_ff, next_in;
   logic [UW-1:0]    used_ff, used_in;
   logic [1:0]       status_ff, status_in;
   logic [5:0]       granted_ff, granted_in;

   logic [CHUNK-1:0] mem [ROWS];
   logic [ROWS-1:0]  row_valid_ff;
   logic [CHUNK-1:0] rd_q;
   logic             rvalid_q;

   logic             rd_en, wr_en;
   logic [RW-1:0]    rd_row;
   logic [CHUNK-1:0] wr_data;

   logic [CHUNK-1:0] word, cand;
   logic             found;
   logic [CB-1:0]    hit;
   logic [PW-1:0]    hit_pos, free_pos;
   logic [RW-1:0]    row_wrap;

   always_comb begin
      word = rvalid_q ? rd_q : '0;
      for (int b = 0; b < CHUNK; b++) begin
         cand[b] = word[b]
            || (32'({row_ff, CB'(b)}) >= 32'(REGS))
            || (first_ff && (CB'(b) < next_ff[CB-1:0]));
      end
      found = 1'b0;
      hit   = '0;
      for (int b = CHUNK - 1; b >= 0; b--) begin
         if (!cand[b]) begin
            found = 1'b1;
            hit   = CB'(b);
         end
      end
      hit_pos  = {row_ff, hit};
      free_pos = PW'(cmd.reg_index);
      row_wrap = (row_ff == RW'(ROWS - 1)) ? '0 : row_ff + RW'(1);
   end

   always_comb begin
      state_in   = state_ff;
      row_in     = row_ff;
      bit_in     = bit_ff;
      first_in   = first_ff;
      next_in    = next_ff;
      used_in    = used_ff;
      status_in  = status_ff;
      granted_in = granted_ff;
      rd_en      = 1'b0;
      rd_row     = row_ff;
      wr_en      = 1'b0;
      wr_data    = word;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               granted_in = '0;
               if (cmd.mode == MODE_FREE) begin
                  if (32'(cmd.reg_index) < 32'(REGS)) begin
                     row_in   = free_pos[PW-1:CB];
                     bit_in   = free_pos[CB-1:0];
                     rd_en    = 1'b1;
                     rd_row   = free_pos[PW-1:CB];
                     state_in = S_FREE;
                  end else begin
                     status_in = ST_IGNORED;
                     state_in  = S_DONE;
                  end
               end else if (32'(used_ff) >= 32'(REGS)) begin
                  status_in = ST_FULL;
                  state_in  = S_DONE;
               end else begin
                  row_in   = next_ff[PW-1:CB];
                  first_in = 1'b1;
                  rd_en    = 1'b1;
                  rd_row   = next_ff[PW-1:CB];
                  state_in = S_SCAN;
               end
            end
         end
         S_FREE: begin
            if (word[bit_ff]) begin
               wr_en     = 1'b1;
               wr_data   = word & ~(CHUNK'(1) << bit_ff);
               used_in   = (used_ff != '0) ? used_ff - UW'(1) : used_ff;
               status_in = ST_FREED;
            end else begin
               status_in = ST_IGNORED;
            end
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (found) begin
               wr_en      = 1'b1;
               wr_data    = word | (CHUNK'(1) << hit);
               granted_in = 6'(hit_pos);
               next_in    = (32'(hit_pos) == 32'(REGS - 1)) ? '0 : hit_pos + PW'(1);
               used_in    = used_ff + UW'(1);
               status_in  = ST_ALLOC;
               state_in   = S_DONE;
            end else begin
               row_in   = row_wrap;
               first_in = 1'b0;
               rd_en    = 1'b1;
               rd_row   = row_wrap;
            end
         end
         S_DONE: begin
            if (ack) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         next_ff  <= '0;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         next_ff  <= next_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff     <= row_in;
      bit_ff     <= bit_in;
      first_ff   <= first_in;
      status_ff  <= status_in;
      granted_ff <= granted_in;
   end

   // row valid bits stand in for clearing the bitmap at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
      end else if (wr_en) begin
         row_valid_ff[row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[row_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_q     <= mem[rd_row];
         rvalid_q <= row_valid_ff[rd_row];
      end
   end

   assign done                 = (state_ff == S_DONE);
   assign result.status        = status_ff;
   assign result.granted_index = granted_ff;

endmodule
`default_nettype wire

// File: hw/rtl/two_pool_next_fit_register_allocator.sv
// Top level of the two-pool next-fit register allocator.
// Two pools (integer, float), each with its busy bitmap held in a one-port-per-side memory
// of 16-bit rows. A request is taken when req_if.ready is high and produces one response.
// Allocation scans one bitmap row per cycle from the pool's next pointer, wrapping once;
// a free reads the register's row and clears its bit, and a full-pool allocation or an
// out-of-range free is answered without a memory read. One request is in flight at a time;
// the next is taken as soon as the previous response is in the output register. Reset takes
// effect through per-row valid bits, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
`include "two_pool_next_fit_register_allocator_defines.svh"
module two_pool_next_fit_register_allocator #(
   parameter int INT_REGS   = 64,
   parameter int FLOAT_REGS = 64
) (
   input  wire       clock,
   input  wire       reset,
   tpnf_req_if.sink  req_if,
   tpnf_rsp_if.source rsp_if
);
   import tpnf_pkg::*;

   logic            busy_ff, busy_in;
   logic            pool_ff, pool_in;
   logic            rsp_valid_ff, rsp_valid_in;
   tpnf_rsp_type    rsp_payload_ff, rsp_payload_in;

   logic            accept, move;
   tpnf_cmd_type    cmd;
   logic            int_done, float_done, sel_done;
   tpnf_result_type int_result, float_result, sel_result;

   assign accept        = req_if.valid && req_if.ready;
   assign cmd.mode      = req_if.payload.mode;
   assign cmd.reg_index = req_if.payload.reg_index;

   tpnf_pool #(.REGS(INT_REGS)) u_int_pool (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_if.payload.pool == POOL_INT)),
      .cmd    (cmd),
      .ack    (move && (pool_ff == POOL_INT)),
      .done   (int_done),
      .result (int_result)
   );

   tpnf_pool #(.REGS(FLOAT_REGS)) u_float_pool (
      .clock  (clock),
      .reset  (reset),
      .start  (accept && (req_if.payload.pool == POOL_FLOAT)),
      .cmd    (cmd),
      .ack    (move && (pool_ff == POOL_FLOAT)),
      .done   (float_done),
      .result (float_result)
   );

   always_comb begin
      sel_done   = (pool_ff == POOL_FLOAT) ? float_done : int_done;
      sel_result = (pool_ff == POOL_FLOAT) ? float_result : int_result;
      move       = busy_ff && sel_done && (!rsp_valid_ff || rsp_if.ready);

      busy_in        = busy_ff;
      pool_in        = pool_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      rsp_payload_in = rsp_payload_ff;
      if (accept) begin
         busy_in = 1'b1;
         pool_in = req_if.payload.pool;
      end
      if (move) begin
         busy_in                      = 1'b0;
         rsp_valid_in                 = 1'b1;
         rsp_payload_in.status        = sel_result.status;
         rsp_payload_in.granted_index = sel_result.granted_index;
         rsp_payload_in.granted_pool  = pool_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pool_ff        <= pool_in;
      rsp_payload_ff <= rsp_payload_in;
   end

   assign req_if.ready   = !busy_ff;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_payload_ff;

   `TPNF_ASSERT_NOW(a_index_zero_unless_alloc, clock, reset,
      rsp_if.valid && (rsp_if.payload.status != ST_ALLOC), rsp_if.payload.granted_index == 6'd0)
   `TPNF_ASSERT_NEXT(a_busy_after_accept, clock, reset, accept, !req_if.ready)
   `TPNF_ASSERT_NEXT(a_move_fills_output, clock, reset, move,
      rsp_if.valid && req_if.ready && (rsp_if.payload.granted_pool == $past(pool_ff)))

endmodule
`default_nettype wire
